// File: rtl/hkrb_pkg.sv
// hkrb_pkg: shared types, constants and key classification for the keyboard report builder
`default_nettype none

package hkrb_pkg;

    // widest report the output carries
    localparam int SLOT_MAX = 6;

    // usage code boundaries
    localparam logic [7:0] MEDIA_FIRST   = 8'hF0;
    localparam logic [7:0] MOD_FIRST     = 8'hE0;
    localparam logic [7:0] MOD_LAST      = 8'hE7;
    localparam logic [7:0] REGULAR_FIRST = 8'h01;
    localparam logic [7:0] REGULAR_LAST  = 8'h65;

    // input item kinds carried on tuser
    localparam logic FUNC_KEY      = 1'b0;
    localparam logic FUNC_END_SCAN = 1'b1;

    typedef enum logic [1:0] {
        CLASS_NONE,
        CLASS_MEDIA,
        CLASS_MODIFIER,
        CLASS_REGULAR
    } key_class_t;

    // report layout, modifier bits in the lowest byte
    typedef struct packed {
        logic [SLOT_MAX-1:0][7:0] slots;
        logic [15:0]              media;
        logic [7:0]               modifier;
    } report_t;

    localparam int REPORT_W = $bits(report_t);

    // command from the input stage to the accumulator
    typedef struct packed {
        logic       take_key;
        logic       emit;
        logic [7:0] code;
    } acc_cmd_t;

    // sort a usage code into its group
    function automatic key_class_t classify(input logic [7:0] code);
        key_class_t cls;
        cls = CLASS_NONE;
        if (code >= MEDIA_FIRST)
            cls = CLASS_MEDIA;
        else if (code >= MOD_FIRST && code <= MOD_LAST)
            cls = CLASS_MODIFIER;
        else if (code >= REGULAR_FIRST && code <= REGULAR_LAST)
            cls = CLASS_REGULAR;
        return cls;
    endfunction

endpackage

`default_nettype wire

// File: rtl/hid_keyboard_report_builder_unit.sv
// hid_keyboard_report_builder_unit: top level of the keyboard report builder
`default_nettype none

// Collects the HID usage codes of one matrix scan and sends one keyboard report per
// scan. Each input transfer is a key code (tuser 0) or an end of scan (tuser 1).
// Media codes 0xF0-0xFF set media bits, 0xE0-0xE7 set modifier bits, 0x01-0x65 fill
// up to KEY_SLOTS key slots in arrival order (extras dropped), all other codes are
// ignored. An end-of-scan transfer yields one 72-bit report and clears the state.
// One item is accepted every cycle unless stalled; the input register feeds the
// accumulator, and the report is captured in the output register as the end-of-scan
// item leaves the input register. Only an end-of-scan item held behind a report not
// yet taken on the master side stalls the slave side.
module hid_keyboard_report_builder_unit #(
    parameter int KEY_SLOTS = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // key_code
    input  logic [0:0]                   s_tuser,   // func
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // modifier_bits, media_bits, key_slot_0 .. key_slot_5
    output logic [hkrb_pkg::REPORT_W-1:0] m_tdata
);
    import hkrb_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic       in_func_reg;
    logic [7:0] in_code_reg;
    logic       out_valid_reg, out_valid_next;
    report_t    out_reg;
    report_t    report;
    acc_cmd_t   cmd;
    logic       stall;
    logic       advance;
    logic       in_take;

    // an end of scan waits only while the previous report is still held
    assign stall    = in_valid_reg && (in_func_reg == FUNC_END_SCAN)
                      && out_valid_reg && !m_tready;
    assign advance  = in_valid_reg && !stall;
    assign s_tready = !stall;
    assign in_take  = s_tvalid && s_tready;

    assign cmd.take_key = advance && (in_func_reg == FUNC_KEY);
    assign cmd.emit     = advance && (in_func_reg == FUNC_END_SCAN);
    assign cmd.code     = in_code_reg;

    // handshake state
    always_comb
    begin
        in_valid_next = stall ? in_valid_reg : s_tvalid;
        priority if (cmd.emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_func_reg <= s_tuser[0];
            in_code_reg <= s_tdata;
        end
    end

    // accumulators
    hkrb_report_acc #(
        .KEY_SLOTS(KEY_SLOTS)
    ) u_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .report(report)
    );

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            out_reg <= report;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // the slave side stalls only behind a held report
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && (in_func_reg == FUNC_END_SCAN)
                       && out_valid_reg && !m_tready))
        else $error("slave side stalled without cause");

    // an emitted scan shows up on the master side
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> m_tvalid)
        else $error("report not presented after end of scan");

    // key items never raise a report
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !cmd.emit) |=> !m_tvalid)
        else $error("report raised without end of scan");

endmodule

`default_nettype wire

// File: rtl/hkrb_report_acc.sv
// hkrb_report_acc: modifier, media and key slot accumulators for one scan
`default_nettype none

module hkrb_report_acc #(
    parameter int KEY_SLOTS = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hkrb_pkg::acc_cmd_t cmd,
    output hkrb_pkg::report_t  report
);
    import hkrb_pkg::*;

    localparam int CW = $clog2(KEY_SLOTS + 1);

    logic [7:0]               modifier_reg, modifier_next;
    logic [15:0]              media_reg, media_next;
    logic [KEY_SLOTS-1:0][7:0] slot_reg, slot_next;
    logic [CW-1:0]            count_reg, count_next;
    key_class_t               cls;
    logic                     slots_full;

    assign cls        = classify(cmd.code);
    assign slots_full = (count_reg == CW'(KEY_SLOTS));

    // next state of the accumulators
    always_comb
    begin
        modifier_next = modifier_reg;
        media_next    = media_reg;
        slot_next     = slot_reg;
        count_next    = count_reg;
        if (cmd.emit)
        begin
            modifier_next = '0;
            media_next    = '0;
            count_next    = '0;
        end
        else if (cmd.take_key)
        begin
            unique case (cls)
                CLASS_MEDIA:
                    media_next = media_reg | (16'd1 << cmd.code[3:0]);
                CLASS_MODIFIER:
                    modifier_next = modifier_reg | (8'd1 << cmd.code[2:0]);
                CLASS_REGULAR:
                begin
                    if (!slots_full)
                    begin
                        for (int i = 0; i < KEY_SLOTS; i++)
                        begin
                            if (count_reg == CW'(i))
                                slot_next[i] = cmd.code;
                        end
                        count_next = count_reg + CW'(1);
                    end
                end
                CLASS_NONE:
                    ;
                default:
                    ;
            endcase
        end
    end

    // control state and masks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modifier_reg <= '0;
            media_reg    <= '0;
            count_reg    <= '0;
        end
        else
        begin
            modifier_reg <= modifier_next;
            media_reg    <= media_next;
            count_reg    <= count_next;
        end
    end

    // slot payload, only read below the fill count
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    // report view: slots at or above the fill count read as zero
    always_comb
    begin
        report.modifier = modifier_reg;
        report.media    = media_reg;
        report.slots    = '0;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (CW'(i) < count_reg)
                report.slots[i] = slot_reg[i];
        end
    end

    // fill count never passes the slot limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(KEY_SLOTS))
        else $error("slot count beyond limit");

    // an emitted scan leaves everything clear
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (count_reg == '0) && (modifier_reg == '0) && (media_reg == '0))
        else $error("state not cleared after end of scan");

    // a full slot store drops further regular codes
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (slots_full && !cmd.emit) |=> slots_full)
        else $error("slot count moved while full");

endmodule

`default_nettype wire
